[hdl/hmd5_pkg.sv]
// Shared types, constants and MD5 tables for the HMAC-MD5 engine.
package hmd5_pkg;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;
  localparam logic [7:0] IPAD = 8'h36;
  localparam logic [7:0] OPAD = 8'h5C;
  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [7:0] NO_PAD = 8'h00;
  localparam logic [5:0] LAST_POS = 6'd63;
  localparam logic [5:0] LEN_POS = 6'd56;
  localparam logic [63:0] BLOCK_BYTES = 64'd64;
  localparam logic [63:0] OUTER_BYTES = 64'd80;
  localparam logic MODE_KEY = 1'b0;
  localparam logic MODE_MSG = 1'b1;

  typedef enum logic [4:0] {
    S_KEY, S_KBYTE, S_KLAST, S_KDIG, S_IPAD, S_MSG, S_MLAST, S_INNER, S_OBLK,
    S_PAD80, S_PADZ, S_PADLEN, S_HWAIT, S_OUT
  } ctl_state_e;

  // Source of a byte written into the block buffer
  typedef enum logic [2:0] {BW_NONE, BW_IN, BW_PEND, BW_MARK, BW_ZERO, BW_LEN} bw_src_e;

  typedef enum logic {HS_KEY, HS_BUF} hash_src_e;

  typedef enum logic [1:0] {LEN_NONE, LEN_CNT, LEN_CNT64, LEN_OUTER} len_sel_e;

  typedef struct packed {
    logic       key_wr;
    bw_src_e    bw;
    logic       cnt_inc;
    logic       cnt_clr;
    logic       hash_start;
    logic       hash_init;
    hash_src_e  hash_src;
    logic [7:0] hash_pad;
    logic       set_hashed;
    logic       clr_key;
    logic       key_from_chain;
    logic       save_inner;
    logic       buf_from_inner;
    len_sel_e   len_sel;
    logic       pos_inc;
    logic       pend_load;
    logic       out_inc;
  } cmd_t;

  typedef struct packed {
    logic hashed;
    logic cnt_lt64;
    logic cnt_lo63;
    logic pos63;
    logic pos56;
    logic pend_last;
    logic hash_done;
    logic out_last;
  } sts_t;

  // Message word index used by round r
  function automatic logic [3:0] md5_g(input logic [5:0] r);
    logic [7:0] rr;
    rr = {2'b00, r};
    case (r[5:4])
      2'd0:    md5_g = r[3:0];
      2'd1:    md5_g = 4'(rr * 8'd5 + 8'd1);
      2'd2:    md5_g = 4'(rr * 8'd3 + 8'd5);
      default: md5_g = 4'(rr * 8'd7);
    endcase
  endfunction

  // Rotate amount of round r
  function automatic logic [4:0] md5_s(input logic [5:0] r);
    case ({r[5:4], r[1:0]})
      4'd0:    md5_s = 5'd7;
      4'd1:    md5_s = 5'd12;
      4'd2:    md5_s = 5'd17;
      4'd3:    md5_s = 5'd22;
      4'd4:    md5_s = 5'd5;
      4'd5:    md5_s = 5'd9;
      4'd6:    md5_s = 5'd14;
      4'd7:    md5_s = 5'd20;
      4'd8:    md5_s = 5'd4;
      4'd9:    md5_s = 5'd11;
      4'd10:   md5_s = 5'd16;
      4'd11:   md5_s = 5'd23;
      4'd12:   md5_s = 5'd6;
      4'd13:   md5_s = 5'd10;
      4'd14:   md5_s = 5'd15;
      default: md5_s = 5'd21;
    endcase
  endfunction

  // Additive round constants
  function automatic logic [31:0] md5_k(input logic [5:0] r);
    case (r)
      6'd0:  md5_k = 32'hd76aa478;  6'd1:  md5_k = 32'he8c7b756;
      6'd2:  md5_k = 32'h242070db;  6'd3:  md5_k = 32'hc1bdceee;
      6'd4:  md5_k = 32'hf57c0faf;  6'd5:  md5_k = 32'h4787c62a;
      6'd6:  md5_k = 32'ha8304613;  6'd7:  md5_k = 32'hfd469501;
      6'd8:  md5_k = 32'h698098d8;  6'd9:  md5_k = 32'h8b44f7af;
      6'd10: md5_k = 32'hffff5bb1;  6'd11: md5_k = 32'h895cd7be;
      6'd12: md5_k = 32'h6b901122;  6'd13: md5_k = 32'hfd987193;
      6'd14: md5_k = 32'ha679438e;  6'd15: md5_k = 32'h49b40821;
      6'd16: md5_k = 32'hf61e2562;  6'd17: md5_k = 32'hc040b340;
      6'd18: md5_k = 32'h265e5a51;  6'd19: md5_k = 32'he9b6c7aa;
      6'd20: md5_k = 32'hd62f105d;  6'd21: md5_k = 32'h02441453;
      6'd22: md5_k = 32'hd8a1e681;  6'd23: md5_k = 32'he7d3fbc8;
      6'd24: md5_k = 32'h21e1cde6;  6'd25: md5_k = 32'hc33707d6;
      6'd26: md5_k = 32'hf4d50d87;  6'd27: md5_k = 32'h455a14ed;
      6'd28: md5_k = 32'ha9e3e905;  6'd29: md5_k = 32'hfcefa3f8;
      6'd30: md5_k = 32'h676f02d9;  6'd31: md5_k = 32'h8d2a4c8a;
      6'd32: md5_k = 32'hfffa3942;  6'd33: md5_k = 32'h8771f681;
      6'd34: md5_k = 32'h6d9d6122;  6'd35: md5_k = 32'hfde5380c;
      6'd36: md5_k = 32'ha4beea44;  6'd37: md5_k = 32'h4bdecfa9;
      6'd38: md5_k = 32'hf6bb4b60;  6'd39: md5_k = 32'hbebfbc70;
      6'd40: md5_k = 32'h289b7ec6;  6'd41: md5_k = 32'heaa127fa;
      6'd42: md5_k = 32'hd4ef3085;  6'd43: md5_k = 32'h04881d05;
      6'd44: md5_k = 32'hd9d4d039;  6'd45: md5_k = 32'he6db99e5;
      6'd46: md5_k = 32'h1fa27cf8;  6'd47: md5_k = 32'hc4ac5665;
      6'd48: md5_k = 32'hf4292244;  6'd49: md5_k = 32'h432aff97;
      6'd50: md5_k = 32'hab9423a7;  6'd51: md5_k = 32'hfc93a039;
      6'd52: md5_k = 32'h655b59c3;  6'd53: md5_k = 32'h8f0ccc92;
      6'd54: md5_k = 32'hffeff47d;  6'd55: md5_k = 32'h85845dd1;
      6'd56: md5_k = 32'h6fa87e4f;  6'd57: md5_k = 32'hfe2ce6e0;
      6'd58: md5_k = 32'ha3014314;  6'd59: md5_k = 32'h4e0811a1;
      6'd60: md5_k = 32'hf7537e82;  6'd61: md5_k = 32'hbd3af235;
      6'd62: md5_k = 32'h2ad7d2bb;  default: md5_k = 32'heb86d391;
    endcase
  endfunction

endpackage

[hdl/hmac_md5_engine_core.sv]
// Top level of the HMAC-MD5 engine: controller plus datapath.
// Takes key bytes (mode 0) closed by a last item, then message bytes (mode 1)
// closed by a last item, and returns the 16 HMAC-MD5 digest bytes in MD5 byte
// order, digest_last marking the sixteenth. Items are taken one per cycle while
// input is not stalled; a request that completes a 64-byte block stalls input (as
// does the first byte past 64 of a long key) while the single MD5 round unit runs
// its 64 rounds (one per cycle) and folds the result into the chaining words.
// Closing a key longer than 64 bytes adds padding plus one or two compressions
// before the ipad compression that ends every key; after the message ends, padding
// plus one or two inner compressions and then two outer compressions run before
// the digest is presented. Input stays stalled while the digest is being delivered.
module hmac_md5_engine_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       mode_i,
  input  logic [7:0] data_byte_i,
  input  logic       carries_byte_i,
  input  logic       last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] digest_byte_o,
  output logic       digest_last_o
);

  hmd5_pkg::cmd_t cmd;
  hmd5_pkg::sts_t sts;

  hmd5_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .carries_byte_i (carries_byte_i),
    .last_i         (last_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .sts_i          (sts),
    .cmd_o          (cmd)
  );

  hmd5_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .data_byte_i   (data_byte_i),
    .last_i        (last_i),
    .digest_byte_o (digest_byte_o),
    .digest_last_o (digest_last_o)
  );

endmodule

[hdl/hmd5_dp.sv]
// Datapath: key and block stores, byte counters, MD5 round unit, digest output.
module hmd5_dp (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  hmd5_pkg::cmd_t  cmd_i,
  output hmd5_pkg::sts_t  sts_o,
  input  logic [7:0]      data_byte_i,
  input  logic            last_i,
  output logic [7:0]      digest_byte_o,
  output logic            digest_last_o
);

  logic [31:0] key_q [16];
  logic [31:0] buf_q [16];
  logic [31:0] chain_q [4];
  logic [31:0] inner_q [4];
  logic [63:0] cnt_q, len_q;
  logic [5:0]  pos_q;
  logic        hashed_q;
  logic [7:0]  pend_byte_q;
  logic        pend_last_q;
  logic [3:0]  out_idx_q;

  // round unit state
  logic        busy_q, fin_q;
  logic [5:0]  rnd_q;
  logic [31:0] a_q, b_q, c_q, d_q, kw_q;
  hmd5_pkg::hash_src_e src_q;
  logic [7:0]  pad_q;

  // Buffer byte write address and data
  logic [5:0]  bw_addr;
  logic [7:0]  bw_data;
  logic [63:0] len_bits;

  assign len_bits = {len_q[60:0], 3'b000};

  always_comb begin
    bw_addr = cnt_q[5:0];
    bw_data = data_byte_i;
    case (cmd_i.bw)
      hmd5_pkg::BW_IN:   bw_data = data_byte_i;
      hmd5_pkg::BW_PEND: bw_data = pend_byte_q;
      hmd5_pkg::BW_MARK: begin
        bw_addr = pos_q;
        bw_data = hmd5_pkg::PAD_MARK;
      end
      hmd5_pkg::BW_ZERO: begin
        bw_addr = pos_q;
        bw_data = hmd5_pkg::NO_PAD;
      end
      hmd5_pkg::BW_LEN: begin
        bw_addr = pos_q;
        bw_data = len_bits[{pos_q[2:0], 3'b000} +: 8];
      end
      default: ;
    endcase
  end

  // Block buffer (no reset, every byte written before use)
  always_ff @(posedge clk_i) begin
    if (cmd_i.bw != hmd5_pkg::BW_NONE) begin
      buf_q[bw_addr[5:2]][{bw_addr[1:0], 3'b000} +: 8] <= bw_data;
    end
    if (cmd_i.buf_from_inner) begin
      for (int i = 0; i < 4; i++) buf_q[i] <= inner_q[i];
    end
  end

  // Key store, cleared at reset and when the last digest byte is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) key_q[i] <= '0;
    end else if (cmd_i.clr_key) begin
      for (int i = 0; i < 16; i++) key_q[i] <= '0;
    end else if (cmd_i.key_from_chain) begin
      for (int i = 0; i < 16; i++) key_q[i] <= (i < 4) ? chain_q[i[1:0]] : '0;
    end else if (cmd_i.key_wr) begin
      key_q[cnt_q[5:2]][{cnt_q[1:0], 3'b000} +: 8] <= data_byte_i;
    end
  end

  // Control-side registers: counters, flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      hashed_q    <= 1'b0;
      pos_q       <= '0;
      out_idx_q   <= '0;
      pend_last_q <= 1'b0;
    end else begin
      if (cmd_i.clr_key || cmd_i.cnt_clr) cnt_q <= '0;
      else if (cmd_i.cnt_inc)             cnt_q <= cnt_q + 64'd1;
      if (cmd_i.clr_key)         hashed_q <= 1'b0;
      else if (cmd_i.set_hashed) hashed_q <= 1'b1;
      case (cmd_i.len_sel)
        hmd5_pkg::LEN_CNT:   pos_q <= cnt_q[5:0];
        hmd5_pkg::LEN_CNT64: pos_q <= cnt_q[5:0];
        hmd5_pkg::LEN_OUTER: pos_q <= hmd5_pkg::OUTER_BYTES[5:0];
        default: if (cmd_i.pos_inc) pos_q <= pos_q + 6'd1;
      endcase
      if (cmd_i.out_inc)   out_idx_q   <= out_idx_q + 4'd1;
      if (cmd_i.pend_load) pend_last_q <= last_i;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.pend_load) pend_byte_q <= data_byte_i;
    case (cmd_i.len_sel)
      hmd5_pkg::LEN_CNT:   len_q <= cnt_q;
      hmd5_pkg::LEN_CNT64: len_q <= cnt_q + hmd5_pkg::BLOCK_BYTES;
      hmd5_pkg::LEN_OUTER: len_q <= hmd5_pkg::OUTER_BYTES;
      default: ;
    endcase
    if (cmd_i.save_inner) begin
      for (int i = 0; i < 4; i++) inner_q[i] <= chain_q[i];
    end
  end

  // Round unit: next round's constant plus message word, one round per cycle
  hmd5_pkg::hash_src_e cur_src;
  logic [7:0]  cur_pad;
  logic [5:0]  nxt_rnd;
  logic [3:0]  g_idx;
  logic [31:0] w_sel, f_val, t_val;
  logic [63:0] rot_w;

  assign cur_src = cmd_i.hash_start ? cmd_i.hash_src : src_q;
  assign cur_pad = cmd_i.hash_start ? cmd_i.hash_pad : pad_q;
  assign nxt_rnd = cmd_i.hash_start ? 6'd0 : rnd_q + 6'd1;
  assign g_idx   = hmd5_pkg::md5_g(nxt_rnd);
  assign w_sel   = (cur_src == hmd5_pkg::HS_KEY) ? (key_q[g_idx] ^ {4{cur_pad}})
                                                 : buf_q[g_idx];

  always_comb begin
    case (rnd_q[5:4])
      2'd0:    f_val = (b_q & c_q) | (~b_q & d_q);
      2'd1:    f_val = (d_q & b_q) | (~d_q & c_q);
      2'd2:    f_val = b_q ^ c_q ^ d_q;
      default: f_val = c_q ^ (b_q | ~d_q);
    endcase
  end

  assign t_val = a_q + f_val + kw_q;
  assign rot_w = {t_val, t_val} << hmd5_pkg::md5_s(rnd_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      rnd_q  <= '0;
      chain_q[0] <= hmd5_pkg::IV_A;
      chain_q[1] <= hmd5_pkg::IV_B;
      chain_q[2] <= hmd5_pkg::IV_C;
      chain_q[3] <= hmd5_pkg::IV_D;
    end else begin
      // one-cycle pulse after the 64th round
      fin_q <= busy_q && !cmd_i.hash_start && (rnd_q == 6'd63);
      if (cmd_i.hash_start) begin
        busy_q <= 1'b1;
        rnd_q  <= '0;
        if (cmd_i.hash_init) begin
          chain_q[0] <= hmd5_pkg::IV_A;
          chain_q[1] <= hmd5_pkg::IV_B;
          chain_q[2] <= hmd5_pkg::IV_C;
          chain_q[3] <= hmd5_pkg::IV_D;
        end
      end else if (busy_q) begin
        rnd_q <= nxt_rnd;
        if (rnd_q == 6'd63) busy_q <= 1'b0;
      end else if (fin_q) begin
        chain_q[0] <= chain_q[0] + a_q;
        chain_q[1] <= chain_q[1] + b_q;
        chain_q[2] <= chain_q[2] + c_q;
        chain_q[3] <= chain_q[3] + d_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.hash_start || busy_q) kw_q <= hmd5_pkg::md5_k(nxt_rnd) + w_sel;
    if (cmd_i.hash_start) begin
      src_q <= cmd_i.hash_src;
      pad_q <= cmd_i.hash_pad;
      a_q <= cmd_i.hash_init ? hmd5_pkg::IV_A : chain_q[0];
      b_q <= cmd_i.hash_init ? hmd5_pkg::IV_B : chain_q[1];
      c_q <= cmd_i.hash_init ? hmd5_pkg::IV_C : chain_q[2];
      d_q <= cmd_i.hash_init ? hmd5_pkg::IV_D : chain_q[3];
    end else if (busy_q) begin
      a_q <= d_q;
      d_q <= c_q;
      c_q <= b_q;
      b_q <= b_q + rot_w[63:32];
    end
  end

  // Status back to the controller
  assign sts_o.hashed    = hashed_q;
  assign sts_o.cnt_lt64  = ~|cnt_q[63:6];
  assign sts_o.cnt_lo63  = (cnt_q[5:0] == hmd5_pkg::LAST_POS);
  assign sts_o.pos63     = (pos_q == hmd5_pkg::LAST_POS);
  assign sts_o.pos56     = (pos_q == hmd5_pkg::LEN_POS);
  assign sts_o.pend_last = pend_last_q;
  assign sts_o.hash_done = fin_q;
  assign sts_o.out_last  = &out_idx_q;

  // Digest bytes, little-endian within each chaining word
  assign digest_byte_o = chain_q[out_idx_q[3:2]][{out_idx_q[1:0], 3'b000} +: 8];
  assign digest_last_o = &out_idx_q;

  // Round unit finishes exactly after its 64th round
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |-> $past(busy_q) && $past(rnd_q) == 6'd63)
    else $error("round unit finished early");

  // The block buffer holds still while rounds read it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cmd_i.bw == hmd5_pkg::BW_NONE && !cmd_i.buf_from_inner)
    else $error("block buffer written during rounds");

  // No new compression while one is running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q || fin_q) |-> !cmd_i.hash_start)
    else $error("compression restarted while busy");

endmodule

[hdl/hmd5_ctrl.sv]
// Controller: sequences key intake, padding, inner and outer hashes, digest output.
module hmd5_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            mode_i,
  input  logic            carries_byte_i,
  input  logic            last_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  input  hmd5_pkg::sts_t  sts_i,
  output hmd5_pkg::cmd_t  cmd_o
);

  hmd5_pkg::ctl_state_e state_q, state_d, ret_q, ret_d, fret_q, fret_d;
  logic in_acc, out_acc, key_acc, msg_acc;

  assign in_stall_o  = !(state_q == hmd5_pkg::S_KEY || state_q == hmd5_pkg::S_MSG);
  assign out_valid_o = (state_q == hmd5_pkg::S_OUT);
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;
  assign key_acc = in_acc && state_q == hmd5_pkg::S_KEY && mode_i == hmd5_pkg::MODE_KEY;
  assign msg_acc = in_acc && state_q == hmd5_pkg::S_MSG && mode_i == hmd5_pkg::MODE_MSG;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hmd5_pkg::S_KEY;
      ret_q   <= hmd5_pkg::S_KEY;
      fret_q  <= hmd5_pkg::S_KEY;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      fret_q  <= fret_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    fret_d  = fret_q;
    case (state_q)
      hmd5_pkg::S_KEY: if (key_acc) begin
        if (carries_byte_i && !sts_i.hashed && sts_i.cnt_lt64) begin
          if (last_i) state_d = hmd5_pkg::S_KLAST;
        end else if (carries_byte_i && !sts_i.hashed) begin
          state_d = hmd5_pkg::S_HWAIT;
          ret_d   = hmd5_pkg::S_KBYTE;
        end else if (carries_byte_i && sts_i.cnt_lo63) begin
          state_d = hmd5_pkg::S_HWAIT;
          ret_d   = hmd5_pkg::S_KLAST;
        end else if (last_i) begin
          state_d = hmd5_pkg::S_KLAST;
        end
      end
      hmd5_pkg::S_KBYTE: begin
        if (sts_i.cnt_lo63) begin
          state_d = hmd5_pkg::S_HWAIT;
          ret_d   = hmd5_pkg::S_KLAST;
        end else begin
          state_d = hmd5_pkg::S_KLAST;
        end
      end
      hmd5_pkg::S_KLAST: begin
        if (!sts_i.pend_last) begin
          state_d = hmd5_pkg::S_KEY;
        end else if (sts_i.hashed) begin
          state_d = hmd5_pkg::S_PAD80;
          fret_d  = hmd5_pkg::S_KDIG;
        end else begin
          state_d = hmd5_pkg::S_IPAD;
        end
      end
      hmd5_pkg::S_KDIG: state_d = hmd5_pkg::S_IPAD;
      hmd5_pkg::S_IPAD: begin
        state_d = hmd5_pkg::S_HWAIT;
        ret_d   = hmd5_pkg::S_MSG;
      end
      hmd5_pkg::S_MSG: if (msg_acc) begin
        if (carries_byte_i && sts_i.cnt_lo63) begin
          state_d = hmd5_pkg::S_HWAIT;
          ret_d   = hmd5_pkg::S_MLAST;
        end else if (last_i) begin
          state_d = hmd5_pkg::S_MLAST;
        end
      end
      hmd5_pkg::S_MLAST: begin
        if (sts_i.pend_last) begin
          state_d = hmd5_pkg::S_PAD80;
          fret_d  = hmd5_pkg::S_INNER;
        end else begin
          state_d = hmd5_pkg::S_MSG;
        end
      end
      hmd5_pkg::S_INNER: begin
        state_d = hmd5_pkg::S_HWAIT;
        ret_d   = hmd5_pkg::S_OBLK;
      end
      hmd5_pkg::S_OBLK: begin
        state_d = hmd5_pkg::S_PAD80;
        fret_d  = hmd5_pkg::S_OUT;
      end
      hmd5_pkg::S_PAD80: begin
        state_d = hmd5_pkg::S_PADZ;
        if (sts_i.pos63) begin
          state_d = hmd5_pkg::S_HWAIT;
          ret_d   = hmd5_pkg::S_PADZ;
        end
      end
      hmd5_pkg::S_PADZ: begin
        if (sts_i.pos56) begin
          state_d = hmd5_pkg::S_PADLEN;
        end else if (sts_i.pos63) begin
          state_d = hmd5_pkg::S_HWAIT;
          ret_d   = hmd5_pkg::S_PADZ;
        end
      end
      hmd5_pkg::S_PADLEN: begin
        if (sts_i.pos63) begin
          state_d = hmd5_pkg::S_HWAIT;
          ret_d   = fret_q;
        end
      end
      hmd5_pkg::S_HWAIT: if (sts_i.hash_done) state_d = ret_q;
      hmd5_pkg::S_OUT: if (out_acc && sts_i.out_last) state_d = hmd5_pkg::S_KEY;
      default: state_d = hmd5_pkg::S_KEY;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd_o = '0;
    cmd_o.bw       = hmd5_pkg::BW_NONE;
    cmd_o.hash_src = hmd5_pkg::HS_BUF;
    cmd_o.len_sel  = hmd5_pkg::LEN_NONE;
    case (state_q)
      hmd5_pkg::S_KEY: if (key_acc) begin
        cmd_o.pend_load = 1'b1;
        if (carries_byte_i && !sts_i.hashed && sts_i.cnt_lt64) begin
          cmd_o.key_wr  = 1'b1;
          cmd_o.cnt_inc = 1'b1;
        end else if (carries_byte_i && !sts_i.hashed) begin
          // long key: compress the first 64 key bytes before taking this one
          cmd_o.hash_start = 1'b1;
          cmd_o.hash_init  = 1'b1;
          cmd_o.hash_src   = hmd5_pkg::HS_KEY;
          cmd_o.hash_pad   = hmd5_pkg::NO_PAD;
        end else if (carries_byte_i) begin
          cmd_o.bw         = hmd5_pkg::BW_IN;
          cmd_o.cnt_inc    = 1'b1;
          cmd_o.hash_start = sts_i.cnt_lo63;
        end
      end
      hmd5_pkg::S_KBYTE: begin
        cmd_o.set_hashed = 1'b1;
        cmd_o.bw         = hmd5_pkg::BW_PEND;
        cmd_o.cnt_inc    = 1'b1;
        cmd_o.hash_start = sts_i.cnt_lo63;
      end
      hmd5_pkg::S_KLAST:
        if (sts_i.pend_last && sts_i.hashed) cmd_o.len_sel = hmd5_pkg::LEN_CNT;
      hmd5_pkg::S_KDIG: cmd_o.key_from_chain = 1'b1;
      hmd5_pkg::S_IPAD: begin
        cmd_o.hash_start = 1'b1;
        cmd_o.hash_init  = 1'b1;
        cmd_o.hash_src   = hmd5_pkg::HS_KEY;
        cmd_o.hash_pad   = hmd5_pkg::IPAD;
        cmd_o.cnt_clr    = 1'b1;
      end
      hmd5_pkg::S_MSG: if (msg_acc) begin
        cmd_o.pend_load = 1'b1;
        if (carries_byte_i) begin
          cmd_o.bw         = hmd5_pkg::BW_IN;
          cmd_o.cnt_inc    = 1'b1;
          cmd_o.hash_start = sts_i.cnt_lo63;
        end
      end
      hmd5_pkg::S_MLAST: if (sts_i.pend_last) cmd_o.len_sel = hmd5_pkg::LEN_CNT64;
      hmd5_pkg::S_INNER: begin
        cmd_o.save_inner = 1'b1;
        cmd_o.hash_start = 1'b1;
        cmd_o.hash_init  = 1'b1;
        cmd_o.hash_src   = hmd5_pkg::HS_KEY;
        cmd_o.hash_pad   = hmd5_pkg::OPAD;
      end
      hmd5_pkg::S_OBLK: begin
        cmd_o.buf_from_inner = 1'b1;
        cmd_o.len_sel        = hmd5_pkg::LEN_OUTER;
      end
      hmd5_pkg::S_PAD80: begin
        cmd_o.bw         = hmd5_pkg::BW_MARK;
        cmd_o.pos_inc    = 1'b1;
        cmd_o.hash_start = sts_i.pos63;
      end
      hmd5_pkg::S_PADZ: if (!sts_i.pos56) begin
        cmd_o.bw         = hmd5_pkg::BW_ZERO;
        cmd_o.pos_inc    = 1'b1;
        cmd_o.hash_start = sts_i.pos63;
      end
      hmd5_pkg::S_PADLEN: begin
        cmd_o.bw         = hmd5_pkg::BW_LEN;
        cmd_o.pos_inc    = 1'b1;
        cmd_o.hash_start = sts_i.pos63;
      end
      hmd5_pkg::S_OUT: if (out_acc) begin
        cmd_o.out_inc = 1'b1;
        cmd_o.clr_key = sts_i.out_last;
      end
      default: ;
    endcase
  end

endmodule

[sim/hmac_md5_engine_core_test.sv]
// Testbench for the HMAC-MD5 engine: directed and random key/message streams checked by a scoreboard.
`timescale 1ns / 100ps

module hmac_md5_engine_core_test;

  // Expected digest bytes and the running HMAC-MD5 model
  class digest_board;
    logic [8:0] want_q[$];
    int unsigned errors;
    int unsigned checked;

    logic [31:0] chain[4];
    logic [7:0] blk_buf[64];
    logic [7:0] key_blk[64];
    logic [63:0] key_cnt;
    logic [63:0] msg_cnt;
    bit key_hashed;
    bit in_msg;

    function new();
      errors = 0;
      checked = 0;
      foreach (blk_buf[i]) blk_buf[i] = '0;
      restart();
    endfunction

    function void iv_load();
      chain[0] = hmd5_pkg::IV_A; chain[1] = hmd5_pkg::IV_B;
      chain[2] = hmd5_pkg::IV_C; chain[3] = hmd5_pkg::IV_D;
    endfunction

    function void restart();
      foreach (key_blk[i]) key_blk[i] = '0;
      key_cnt = '0;
      msg_cnt = '0;
      key_hashed = 0;
      in_msg = 0;
      iv_load();
    endfunction

    // One MD5 compression over a 64-byte block
    function void compress(logic [7:0] b[64]);
      logic [31:0] w[16];
      logic [31:0] a, bb, c, d, f, t;
      int unsigned g, s;
      int unsigned sh[16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
      logic [31:0] kk;
      for (int i = 0; i < 16; i++)
        w[i] = {b[4*i+3], b[4*i+2], b[4*i+1], b[4*i]};
      a = chain[0]; bb = chain[1]; c = chain[2]; d = chain[3];
      for (int i = 0; i < 64; i++) begin
        if (i < 16) begin f = (bb & c) | (~bb & d); g = i; end
        else if (i < 32) begin f = (d & bb) | (~d & c); g = (5*i + 1) % 16; end
        else if (i < 48) begin f = bb ^ c ^ d; g = (3*i + 5) % 16; end
        else begin f = c ^ (bb | ~d); g = (7*i) % 16; end
        s = sh[(i / 16) * 4 + (i % 4)];
        kk = sine_k(i);
        t = a + f + kk + w[g];
        a = d; d = c; c = bb;
        bb = bb + ((t << s) | (t >> (32 - s)));
      end
      chain[0] += a; chain[1] += bb; chain[2] += c; chain[3] += d;
    endfunction

    // MD5 constant floor(abs(sin(i+1)) * 2^32), exact in double precision
    function logic [31:0] sine_k(int i);
      real v;
      v = $sin(i + 1.0);
      if (v < 0) v = -v;
      return 32'(longint'($floor(v * 4294967296.0)));
    endfunction

    function void finish_pad(logic [63:0] total);
      int unsigned n;
      logic [63:0] bits;
      n = total[5:0];
      bits = total << 3;
      blk_buf[n] = hmd5_pkg::PAD_MARK;
      n++;
      if (n > 56) begin
        while (n < 64) begin blk_buf[n] = hmd5_pkg::NO_PAD; n++; end
        compress(blk_buf);
        n = 0;
      end
      while (n < 56) begin blk_buf[n] = hmd5_pkg::NO_PAD; n++; end
      for (int i = 0; i < 8; i++) blk_buf[56+i] = bits[8*i +: 8];
      compress(blk_buf);
    endfunction

    function void padded_key(logic [7:0] pad);
      logic [7:0] b[64];
      iv_load();
      foreach (b[i]) b[i] = key_blk[i] ^ pad;
      compress(b);
    endfunction

    // Note an accepted request and queue any digest it completes
    function void note_request(bit mode, logic [7:0] dbyte, bit has, bit lst);
      logic [7:0] inner[16];
      logic [8:0] ent;
      if (!in_msg) begin
        if (mode != hmd5_pkg::MODE_KEY) return;
        if (has) begin
          if (!key_hashed && key_cnt < 64) key_blk[key_cnt[5:0]] = dbyte;
          else begin
            if (!key_hashed) begin
              iv_load();
              compress(key_blk);
              key_hashed = 1;
            end
            blk_buf[key_cnt[5:0]] = dbyte;
            if (key_cnt[5:0] == hmd5_pkg::LAST_POS) compress(blk_buf);
          end
          key_cnt++;
        end
        if (lst) begin
          if (key_hashed) begin
            finish_pad(key_cnt);
            foreach (key_blk[i]) key_blk[i] = '0;
            for (int i = 0; i < 16; i++) key_blk[i] = chain[i/4][8*(i%4) +: 8];
          end
          padded_key(hmd5_pkg::IPAD);
          msg_cnt = '0;
          in_msg = 1;
        end
        return;
      end
      if (mode != hmd5_pkg::MODE_MSG) return;
      if (has) begin
        blk_buf[msg_cnt[5:0]] = dbyte;
        msg_cnt++;
        if (msg_cnt[5:0] == 0) compress(blk_buf);
      end
      if (!lst) return;
      finish_pad(msg_cnt + hmd5_pkg::BLOCK_BYTES);
      for (int i = 0; i < 16; i++) inner[i] = chain[i/4][8*(i%4) +: 8];
      padded_key(hmd5_pkg::OPAD);
      for (int i = 0; i < 16; i++) blk_buf[i] = inner[i];
      finish_pad(hmd5_pkg::OUTER_BYTES);
      for (int i = 0; i < 16; i++) begin
        ent = {i == 15, chain[i/4][8*(i%4) +: 8]};
        want_q.insert(want_q.size(), ent);
      end
      restart();
    endfunction

    function void check_digest(logic [7:0] got_byte, logic got_last);
      logic [8:0] w;
      checked++;
      if (want_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected digest byte %h last %b", got_byte, got_last);
        return;
      end
      w = want_q.pop_front();
      if (w[7:0] !== got_byte || w[8] !== got_last) begin
        errors++;
        if (errors <= 10)
          $display("digest mismatch: want byte %h last %b, got byte %h last %b",
                   w[7:0], w[8], got_byte, got_last);
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid_i = 0;
  logic in_stall_o;
  logic mode_i = 0;
  logic [7:0] data_byte_i = 0;
  logic carries_byte_i = 0;
  logic last_i = 0;
  logic out_valid_o;
  logic out_stall_i = 0;
  logic [7:0] digest_byte_o;
  logic digest_last_o;

  int unsigned send_idle_pct = 9;
  int unsigned recv_idle_pct = 84;
  digest_board board = new();

  hmac_md5_engine_core dut (.*);

  always #5 clk_i = ~clk_i;

  // Receiver: random stall, check each accepted digest byte
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_digest(digest_byte_o, digest_last_o);
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // Drive one request and hold it until accepted
  task automatic send_request(bit mode, logic [7:0] dbyte, bit has, bit lst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1;
    mode_i <= mode;
    data_byte_i <= dbyte;
    carries_byte_i <= has;
    last_i <= lst;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_request(mode, dbyte, has, lst);
  endtask

  // Key then message; lengths chosen by the caller, content random
  task automatic send_pair(int unsigned klen, int unsigned mlen, bit empty_end);
    for (int i = 0; i < klen; i++)
      send_request(hmd5_pkg::MODE_KEY, 8'($urandom), 1, (i == klen - 1) && !empty_end);
    if (empty_end || klen == 0) send_request(hmd5_pkg::MODE_KEY, 8'($urandom), 0, 1);
    for (int i = 0; i < mlen; i++)
      send_request(hmd5_pkg::MODE_MSG, 8'($urandom), 1, (i == mlen - 1) && !empty_end);
    if (empty_end || mlen == 0) send_request(hmd5_pkg::MODE_MSG, 8'($urandom), 0, 1);
  endtask

  task automatic random_pair();
    int unsigned klen, mlen;
    klen = $urandom_range(6);
    mlen = $urandom_range(10);
    send_pair(klen, mlen, $urandom_range(3) == 0);
    // occasional noise: a message request while a key is expected
    if ($urandom_range(3) == 0)
      send_request(hmd5_pkg::MODE_MSG, 8'($urandom), 1, $urandom_range(1));
  endtask

  task automatic drain();
    int unsigned guard;
    guard = 0;
    in_valid_i <= 0;
    while (board.want_q.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (300) @(posedge clk_i);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    for (int p = 0; p < 3; p++) begin
      if (p == 1) begin send_idle_pct = 84; recv_idle_pct = 9; end
      if (p == 2) begin send_idle_pct = 0; recv_idle_pct = 0; end
      if (p == 0) begin
        // Directed: empty key and message, ignored requests, extreme bytes
        send_request(hmd5_pkg::MODE_MSG, 8'hFF, 1, 1);
        send_request(hmd5_pkg::MODE_KEY, 8'h00, 0, 0);
        send_request(hmd5_pkg::MODE_KEY, 8'h00, 1, 0);
        send_request(hmd5_pkg::MODE_KEY, 8'hFF, 1, 1);
        send_request(hmd5_pkg::MODE_KEY, 8'hAA, 1, 1);
        send_request(hmd5_pkg::MODE_MSG, 8'h00, 0, 0);
        send_request(hmd5_pkg::MODE_MSG, 8'hFF, 1, 0);
        send_request(hmd5_pkg::MODE_MSG, 8'h55, 0, 1);
        send_pair(0, 0, 1);
        // long key hashed down, message tail that needs two padding blocks
        send_pair(65, 56, 0);
      end
      for (int n = 0; n < 2; n++) random_pair();
    end
    drain();
    if (board.errors == 0 && board.want_q.size() == 0)
      $display("hmac_md5_engine_core verification clean");
    else
      $display("hmac_md5_engine_core verification failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("hmac_md5_engine_core verification failed");
    $finish;
  end
endmodule

[sim.f]
hdl/hmd5_pkg.sv
hdl/hmd5_dp.sv
hdl/hmd5_ctrl.sv
hdl/hmac_md5_engine_core.sv
sim/hmac_md5_engine_core_test.sv
